// ===== sv/ini_text_tokenizer_defines.svh =====
// ----------------------------------------------------------------------------
// ini_text_tokenizer assertion macros
// Clocked concurrent assertion wrappers, empty when synthesised.
// ----------------------------------------------------------------------------
`ifndef INI_TEXT_TOKENIZER_DEFINES_SVH
`define INI_TEXT_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS
`define ITT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define ITT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ITT_ASSERT(lbl, prop, msg)
`define ITT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/itt_pkg.sv =====
// ----------------------------------------------------------------------------
// itt_pkg
// Types and constants shared by the INI text tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package itt_pkg;

    typedef enum logic [2:0] {
        PH_LINE    = 3'd0,
        PH_SECTION = 3'd1,
        PH_KEY     = 3'd2,
        PH_VALUE   = 3'd3,
        PH_COMMENT = 3'd4
    } t_phase;

    localparam logic [2:0] ROLE_SPACE   = 3'd0;
    localparam logic [2:0] ROLE_SECTION = 3'd1;
    localparam logic [2:0] ROLE_KEY     = 3'd2;
    localparam logic [2:0] ROLE_VALUE   = 3'd3;
    localparam logic [2:0] ROLE_COMMENT = 3'd4;
    localparam logic [2:0] ROLE_DELIM   = 3'd5;
    localparam logic [2:0] ROLE_EOL     = 3'd6;

    localparam logic [1:0] ERR_EMPTY_SECTION = 2'd0;
    localparam logic [1:0] ERR_NO_EQUALS     = 2'd1;
    localparam logic [1:0] ERR_UNTERMINATED  = 2'd2;

    localparam logic [2:0] CFG_CMT_FIRST = 3'd0;
    localparam logic [2:0] CFG_CMT_USE   = 3'd4;
    localparam logic [2:0] CFG_LINE_END  = 3'd5;

    localparam int unsigned CMT_REGS = 4;
    localparam logic [7:0]  CMT_RESET [CMT_REGS] = '{8'd35, 8'd59, 8'd0, 8'd0};
    localparam logic [2:0]  CMT_USE_RESET  = 3'd2;
    localparam logic [7:0]  LINE_END_RESET = 8'd10;

    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_EQUALS   = 8'h3D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;

    localparam int unsigned QDEPTH = 2;

    typedef struct packed {
        logic is_end;
        logic is_cmt;
        logic is_space;
        logic is_lbr;
        logic is_rbr;
        logic is_eq;
        logic first;
        logic last;
    } t_qitem;

    typedef struct packed {
        logic [2:0]  byte_role;
        logic        section_done;
        logic        entry_done;
        logic        default_opened;
        logic        error_seen;
        logic [1:0]  error_kind;
        logic [15:0] line_number;
        logic [15:0] column_number;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/itt_in_if.sv =====
// ----------------------------------------------------------------------------
// itt_in_if
// Text byte channel into the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

interface itt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       first_of_text;
    logic       last_of_text;

    modport source (output valid, text_byte, first_of_text, last_of_text, input ready);
    modport sink   (input valid, text_byte, first_of_text, last_of_text, output ready);
endinterface

`default_nettype wire

// ===== sv/itt_out_if.sv =====
// ----------------------------------------------------------------------------
// itt_out_if
// Token result channel out of the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

interface itt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_role;
    logic        section_done;
    logic        entry_done;
    logic        default_opened;
    logic        error_seen;
    logic [1:0]  error_kind;
    logic [15:0] line_number;
    logic [15:0] column_number;

    modport source (output valid, byte_role, section_done, entry_done, default_opened,
                    error_seen, error_kind, line_number, column_number, input ready);
    modport sink   (input valid, byte_role, section_done, entry_done, default_opened,
                    error_seen, error_kind, line_number, column_number, output ready);
endinterface

`default_nettype wire

// ===== sv/itt_cfg_if.sv =====
// ----------------------------------------------------------------------------
// itt_cfg_if
// Register write channel of the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

interface itt_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/itt_front.sv =====
// ----------------------------------------------------------------------------
// itt_front
// Holds the registers, accepts text bytes and classifies each one.
// ----------------------------------------------------------------------------
`default_nettype none

module itt_front import itt_pkg::*; #(
    parameter int unsigned MAX_COMMENT_CHARS = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    itt_in_if.sink  i_text,
    itt_cfg_if.sink i_cfg,
    output logic   o_push,
    output t_qitem o_item,
    input  logic   i_q_ready
);

    localparam int unsigned NUM_CMT =
        (MAX_COMMENT_CHARS < CMT_REGS) ? MAX_COMMENT_CHARS : CMT_REGS;

    logic [7:0] r_cmt [NUM_CMT];
    logic [2:0] r_cmt_use;
    logic [7:0] r_line_end;
    logic       cfg_wr;
    logic       cmt_hit;
    logic [7:0] b;

    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CMT; i++) r_cmt[i] <= CMT_RESET[i];
            r_cmt_use  <= CMT_USE_RESET;
            r_line_end <= LINE_END_RESET;
        end else if (cfg_wr) begin
            for (int i = 0; i < NUM_CMT; i++) begin
                if (i_cfg.index == CFG_CMT_FIRST + 3'(i)) r_cmt[i] <= i_cfg.data;
            end
            if (i_cfg.index == CFG_CMT_USE)  r_cmt_use  <= i_cfg.data[2:0];
            if (i_cfg.index == CFG_LINE_END) r_line_end <= i_cfg.data;
        end
    end

    assign b = i_text.text_byte;

    always_comb begin
        cmt_hit = 1'b0;
        for (int i = 0; i < NUM_CMT; i++) begin
            if ((3'(i) < r_cmt_use) && (r_cmt[i] == b)) cmt_hit = 1'b1;
        end
    end

    assign i_text.ready    = i_q_ready;
    assign o_push          = i_text.valid && i_q_ready;
    assign o_item.is_end   = (b == r_line_end);
    assign o_item.is_cmt   = cmt_hit;
    assign o_item.is_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    assign o_item.is_lbr   = (b == CH_LBRACKET);
    assign o_item.is_rbr   = (b == CH_RBRACKET);
    assign o_item.is_eq    = (b == CH_EQUALS);
    assign o_item.first    = i_text.first_of_text;
    assign o_item.last     = i_text.last_of_text;

endmodule

`default_nettype wire

// ===== sv/itt_queue.sv =====
// ----------------------------------------------------------------------------
// itt_queue
// Short FIFO of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ini_text_tokenizer_defines.svh"

module itt_queue import itt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qitem i_item,
    output logic   o_ready,
    input  logic   i_pop,
    output t_qitem o_item,
    output logic   o_valid
);

    localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned CW = $clog2(QDEPTH + 1);

    t_qitem        r_mem [QDEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(QDEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_ready = (r_count != CW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= ptr_inc(r_wr);
            if (i_pop)  r_rd <= ptr_inc(r_rd);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `ITT_ASSERT(a_no_overflow, !(i_push && !o_ready), "queue pushed while full")
    `ITT_ASSERT(a_no_underflow, !(i_pop && !o_valid), "queue popped while empty")

endmodule

`default_nettype wire

// ===== sv/itt_back.sv =====
// ----------------------------------------------------------------------------
// itt_back
// Parse state machine, counters, sticky error and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ini_text_tokenizer_defines.svh"

module itt_back import itt_pkg::*; #(
    parameter int unsigned COUNTER_BITS = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_q_valid,
    input  t_qitem i_item,
    output logic   o_pop,
    itt_out_if.source o_tok
);

    t_phase                  r_phase, e_phase, s_mid, n_phase;
    logic                    r_sec_open, e_sec_open, n_sec_open;
    logic                    r_name_ne, e_name_ne, n_name_ne;
    logic                    r_err_valid, e_err_valid, n_err_valid;
    logic [1:0]              r_err_code, e_err_code, n_err_code;
    logic [COUNTER_BITS-1:0] r_line, e_line, n_line;
    logic [COUNTER_BITS-1:0] r_col, e_col, n_col;
    logic                    r_out_valid;
    t_result                 r_out, n_out;
    logic                    raise;
    logic [1:0]              raise_code;
    logic [2:0]              role;
    logic                    sec_done, ent_done, dflt;

    assign o_pop = i_q_valid && (!r_out_valid || o_tok.ready);

    // first_of_text clears before the byte is parsed
    assign e_phase     = i_item.first ? PH_LINE : r_phase;
    assign e_sec_open  = i_item.first ? 1'b0 : r_sec_open;
    assign e_name_ne   = i_item.first ? 1'b0 : r_name_ne;
    assign e_err_valid = i_item.first ? 1'b0 : r_err_valid;
    assign e_err_code  = i_item.first ? ERR_EMPTY_SECTION : r_err_code;
    assign e_line      = i_item.first ? '0 : r_line;
    assign e_col       = i_item.first ? '0 : r_col;

    // next state
    always_comb begin
        s_mid = e_phase;
        unique case (e_phase)
            PH_SECTION: begin
                if (i_item.is_rbr && !i_item.is_end) s_mid = PH_LINE;
            end
            PH_KEY: begin
                if (i_item.is_end)      s_mid = PH_LINE;
                else if (i_item.is_cmt) s_mid = PH_COMMENT;
                else if (i_item.is_eq)  s_mid = PH_VALUE;
            end
            PH_VALUE: begin
                if (i_item.is_end)      s_mid = PH_LINE;
                else if (i_item.is_cmt) s_mid = PH_COMMENT;
            end
            PH_COMMENT: begin
                if (i_item.is_end) s_mid = PH_LINE;
            end
            default: begin
                if (i_item.is_end || i_item.is_space) s_mid = PH_LINE;
                else if (i_item.is_lbr)               s_mid = PH_SECTION;
                else if (i_item.is_cmt)               s_mid = PH_COMMENT;
                else if (i_item.is_eq)                s_mid = PH_VALUE;
                else                                  s_mid = PH_KEY;
            end
        endcase
        n_phase = i_item.last ? PH_LINE : s_mid;
    end

    // outputs
    always_comb begin
        role       = ROLE_SPACE;
        sec_done   = 1'b0;
        ent_done   = 1'b0;
        dflt       = 1'b0;
        raise      = 1'b0;
        raise_code = ERR_EMPTY_SECTION;
        n_sec_open = e_sec_open;
        n_name_ne  = e_name_ne;
        unique case (e_phase)
            PH_SECTION: begin
                if (i_item.is_rbr && !i_item.is_end) begin
                    role = ROLE_DELIM;
                    if (e_name_ne) begin
                        sec_done   = 1'b1;
                        n_sec_open = 1'b1;
                    end else begin
                        raise      = 1'b1;
                        raise_code = ERR_EMPTY_SECTION;
                    end
                end else begin
                    role      = ROLE_SECTION;
                    n_name_ne = 1'b1;
                end
            end
            PH_KEY: begin
                if (i_item.is_end) begin
                    role       = ROLE_EOL;
                    raise      = 1'b1;
                    raise_code = ERR_NO_EQUALS;
                end else if (i_item.is_cmt) begin
                    role = ROLE_COMMENT;
                end else if (i_item.is_eq) begin
                    role = ROLE_DELIM;
                end else begin
                    role = ROLE_KEY;
                end
            end
            PH_VALUE: begin
                if (i_item.is_end) begin
                    role     = ROLE_EOL;
                    ent_done = 1'b1;
                end else if (i_item.is_cmt) begin
                    role     = ROLE_COMMENT;
                    ent_done = 1'b1;
                end else begin
                    role = ROLE_VALUE;
                end
            end
            PH_COMMENT: begin
                role = i_item.is_end ? ROLE_EOL : ROLE_COMMENT;
            end
            default: begin
                if (i_item.is_end) begin
                    role = ROLE_EOL;
                end else if (i_item.is_space) begin
                    role = ROLE_SPACE;
                end else if (i_item.is_lbr) begin
                    role      = ROLE_DELIM;
                    n_name_ne = 1'b0;
                end else begin
                    if (!e_sec_open) begin
                        n_sec_open = 1'b1;
                        dflt       = 1'b1;
                    end
                    if (i_item.is_cmt)     role = ROLE_COMMENT;
                    else if (i_item.is_eq) role = ROLE_DELIM;
                    else                   role = ROLE_KEY;
                end
            end
        endcase

        if (i_item.last) begin
            if (s_mid == PH_VALUE) begin
                ent_done = 1'b1;
            end else if ((s_mid == PH_KEY || s_mid == PH_SECTION) && !raise) begin
                raise      = 1'b1;
                raise_code = ERR_UNTERMINATED;
            end
        end

        n_err_valid = e_err_valid || raise;
        n_err_code  = e_err_valid ? e_err_code : raise_code;

        if (i_item.is_end) begin
            n_line = (e_line != '1) ? e_line + COUNTER_BITS'(1) : e_line;
            n_col  = '0;
        end else begin
            n_line = e_line;
            n_col  = (e_col != '1) ? e_col + COUNTER_BITS'(1) : e_col;
        end

        n_out.byte_role      = role;
        n_out.section_done   = sec_done;
        n_out.entry_done     = ent_done;
        n_out.default_opened = dflt;
        n_out.error_seen     = n_err_valid;
        n_out.error_kind     = n_err_valid ? n_err_code : ERR_EMPTY_SECTION;
        n_out.line_number    = 16'(e_line);
        n_out.column_number  = 16'(e_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LINE;
            r_sec_open  <= 1'b0;
            r_name_ne   <= 1'b0;
            r_err_valid <= 1'b0;
            r_err_code  <= ERR_EMPTY_SECTION;
            r_line      <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_sec_open  <= n_sec_open;
                r_name_ne   <= n_name_ne;
                r_err_valid <= n_err_valid;
                r_err_code  <= n_err_code;
                r_line      <= n_line;
                r_col       <= n_col;
                r_out_valid <= 1'b1;
            end else if (o_tok.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_out <= n_out;
    end

    assign o_tok.valid          = r_out_valid;
    assign o_tok.byte_role      = r_out.byte_role;
    assign o_tok.section_done   = r_out.section_done;
    assign o_tok.entry_done     = r_out.entry_done;
    assign o_tok.default_opened = r_out.default_opened;
    assign o_tok.error_seen     = r_out.error_seen;
    assign o_tok.error_kind     = r_out.error_kind;
    assign o_tok.line_number    = r_out.line_number;
    assign o_tok.column_number  = r_out.column_number;

    `ITT_ASSERT_NEXT(a_err_sticky, r_err_valid && !(o_pop && i_item.first),
                     r_err_valid && $stable(r_err_code), "held error lost or changed")
    `ITT_ASSERT_NEXT(a_col_clear, o_pop && i_item.is_end, r_col == '0,
                     "column not cleared after line end")
    `ITT_ASSERT_NEXT(a_line_hold, o_pop && !i_item.is_end && !i_item.first,
                     $stable(r_line), "line counter moved without line end")
    `ITT_ASSERT_NEXT(a_state_hold, !o_pop, $stable(r_phase) && $stable(r_col),
                     "parse state moved without an item")

endmodule

`default_nettype wire

// ===== sv/ini_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// ini_text_tokenizer
// Byte-wise INI text tokenizer: roles, section and entry events, positions.
// ----------------------------------------------------------------------------
// One text byte is accepted every clock cycle while input ready is high, and one
// result is returned for each byte, in order. A byte passes the classifier into
// a two-entry queue, then the parse state machine writes its result into an
// output register, so each result passes the queue entry and then the output
// register before it appears. The feedback of the parse state and counters in
// the back end sets the rate of one byte per cycle. Back-pressure on the result
// channel fills the queue and then lowers input ready. The register port is always
// ready and must only be written while no byte is in flight; no clearing pass follows reset.
`default_nettype none

module ini_text_tokenizer import itt_pkg::*; #(
    parameter int unsigned MAX_COMMENT_CHARS = 4,
    parameter int unsigned COUNTER_BITS      = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    itt_in_if.sink    i_text,
    itt_cfg_if.sink   i_cfg,
    itt_out_if.source o_tok
);

    logic   push, q_ready, q_valid, pop;
    t_qitem push_item, pop_item;

    itt_front #(
        .MAX_COMMENT_CHARS (MAX_COMMENT_CHARS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_text    (i_text),
        .i_cfg     (i_cfg),
        .o_push    (push),
        .o_item    (push_item),
        .i_q_ready (q_ready)
    );

    itt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_valid (q_valid)
    );

    itt_back #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (pop_item),
        .o_pop     (pop),
        .o_tok     (o_tok)
    );

endmodule

`default_nettype wire
